@@ rtl/lpse_pkg.sv @@
// ----------------------------------------------------------------------------
// lpse_pkg
// Shared types and constants for the LED pixel SPI symbol encoder.
// ----------------------------------------------------------------------------
package lpse_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam int COLOR_W    = 24;
  localparam int POS_W      = 4;
  localparam int GRADE_W    = 3;

  localparam logic [CFG_IDX_W-1:0] REG_DIM_GRADE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_STEP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLANK_COLOR = 2'd2;

  localparam logic [GRADE_W-1:0] GRADE_THIRD     = 3'd1;
  localparam logic [GRADE_W-1:0] GRADE_ALTERNATE = 3'd2;
  localparam logic [GRADE_W-1:0] GRADE_THREE_OF4 = 3'd3;
  localparam logic [GRADE_W-1:0] GRADE_ALL       = 3'd4;

  localparam logic [POS_W-1:0] POS_LAST = 4'd11;

  localparam logic [7:0] SYM_ONE   = 8'hF0;
  localparam logic [7:0] SYM_ZERO  = 8'h30;
  localparam logic [7:0] SYM_RESET = 8'h00;

  localparam int PIXEL_BYTES = 24;

  typedef struct packed {
    logic               is_reset;
    logic [COLOR_W-1:0] color;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

@@ rtl/lpse_front.sv @@
// ----------------------------------------------------------------------------
// lpse_front
// Config registers, frame position tracking, dimming and temperature
// adjustment; turns each accepted input beat into one command word.
// ----------------------------------------------------------------------------
module lpse_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  input  logic [lpse_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lpse_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                          in_fire,
  input  logic                          in_mode,
  input  logic [7:0]                    in_byte0,
  input  logic [7:0]                    in_byte1,
  input  logic [7:0]                    in_byte2,
  output lpse_pkg::cmd_t                cmd
);
  import lpse_pkg::*;

  logic [GRADE_W-1:0] dim_grade_r;
  logic [7:0]         temp_step_r;
  logic [COLOR_W-1:0] blank_color_r;
  logic [POS_W-1:0]   pos_r;
  logic [POS_W-1:0]   pos_nxt;
  logic               blanked;
  logic [7:0]         adj0;
  logic [7:0]         adj2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_grade_r   <= '0;
      temp_step_r   <= '0;
      blank_color_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DIM_GRADE:   dim_grade_r   <= cfg_wdata[GRADE_W-1:0];
        REG_TEMP_STEP:   temp_step_r   <= cfg_wdata[7:0];
        REG_BLANK_COLOR: blank_color_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // position holds (k-1) mod 12
  always_comb begin
    case (dim_grade_r)
      GRADE_THIRD:     blanked = pos_r inside {4'd2, 4'd5, 4'd8, 4'd11};
      GRADE_ALTERNATE: blanked = pos_r[0];
      GRADE_THREE_OF4: blanked = (pos_r[1:0] != 2'd0);
      GRADE_ALL:       blanked = 1'b1;
      default:         blanked = 1'b0;
    endcase
  end

  assign adj0 = in_byte0 + {temp_step_r[6:0], 1'b0};
  assign adj2 = in_byte2 + {temp_step_r[5:0], 2'b00};

  always_comb begin
    cmd.is_reset = in_mode;
    cmd.color    = blanked ? blank_color_r : {adj0, in_byte1, adj2};
  end

  always_comb begin
    if (in_mode || pos_r == POS_LAST) begin
      pos_nxt = '0;
    end else begin
      pos_nxt = pos_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (in_fire) begin
      pos_r <= pos_nxt;
    end
  end

endmodule

@@ rtl/lpse_queue.sv @@
// ----------------------------------------------------------------------------
// lpse_queue
// Two-entry command queue between the front and the serializer.
// ----------------------------------------------------------------------------
module lpse_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  lpse_pkg::cmd_t      push_cmd,
  input  logic                pop,
  output lpse_pkg::cmd_t      head_cmd,
  output lpse_pkg::q_status_t status
);
  import lpse_pkg::*;

  cmd_t       entry_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic [1:0] count_nxt;

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end

  assign head_cmd     = entry_r[rd_ptr_r];
  assign status.full  = (count_r == 2'd2);
  assign status.empty = (count_r == 2'd0);

endmodule

@@ rtl/lpse_back.sv @@
// ----------------------------------------------------------------------------
// lpse_back
// Serializer: walks the head command byte by byte into the output register.
// ----------------------------------------------------------------------------
module lpse_back #(
  parameter int RESET_BYTES = 33
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           head_valid,
  input  lpse_pkg::cmd_t head_cmd,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_spi_byte,
  output logic           out_last
);
  import lpse_pkg::*;

  localparam int MAX_BYTES = (RESET_BYTES > PIXEL_BYTES) ? RESET_BYTES : PIXEL_BYTES;
  localparam int CW        = $clog2(MAX_BYTES);

  logic [CW-1:0] idx_r;
  logic          out_valid_r;
  logic [7:0]    spi_r;
  logic          last_r;
  logic          advance;
  logic          is_last;
  logic [4:0]    bit_sel;
  logic [7:0]    sym;

  assign advance = head_valid && (!out_valid_r || out_ready);
  assign bit_sel = 5'(PIXEL_BYTES - 1) - idx_r[4:0];
  assign is_last = head_cmd.is_reset ? (idx_r == CW'(RESET_BYTES - 1))
                                     : (idx_r == CW'(PIXEL_BYTES - 1));

  always_comb begin
    if (head_cmd.is_reset) begin
      sym = SYM_RESET;
    end else if (head_cmd.color[bit_sel]) begin
      sym = SYM_ONE;
    end else begin
      sym = SYM_ZERO;
    end
  end

  assign pop = advance && is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      idx_r       <= is_last ? '0 : idx_r + CW'(1);
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      spi_r  <= sym;
      last_r <= is_last;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_spi_byte = spi_r;
  assign out_last     = last_r;

endmodule

@@ rtl/led_pixel_spi_symbol_encoder_core.sv @@
// ----------------------------------------------------------------------------
// led_pixel_spi_symbol_encoder_core
// Encodes LED pixels into SPI symbol bytes with dimming and color temperature.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one beat per pixel (in_mode 0) or frame reset (in_mode 1)
//   out_* : one SPI symbol byte per beat, out_last on the final byte of a run
//   cfg_* : register writes (dim grade, temp step, blank color), always ready;
//           write only while the block is idle
// A pixel becomes 24 bytes (0xF0 per one, 0x30 per zero, MSB first); a frame
// reset becomes RESET_BYTES zero bytes and restarts the position count.
// An accepted beat is written into the command queue, and the serializer
// registers its first byte once the beat reaches the queue head. Throughput:
// one byte per cycle from the serializer while out_ready holds. A two-entry
// command queue lets input beats be accepted while the serializer runs.
// Reset clears config, position, queue and output valid. When the receiver
// stalls, the output byte holds and the queue fills; in_ready drops when full.
// ----------------------------------------------------------------------------
module led_pixel_spi_symbol_encoder_core #(
  parameter int RESET_BYTES = 33
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lpse_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lpse_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_mode,
  input  logic [7:0]                    in_byte0,
  input  logic [7:0]                    in_byte1,
  input  logic [7:0]                    in_byte2,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    out_spi_byte,
  output logic                          out_last
);
  import lpse_pkg::*;

  cmd_t      front_cmd;
  cmd_t      head_cmd;
  q_status_t q_status;
  logic      in_fire;
  logic      pop;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_status.full;
  assign in_fire   = in_valid && in_ready;

  lpse_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_fire   (in_fire),
    .in_mode   (in_mode),
    .in_byte0  (in_byte0),
    .in_byte1  (in_byte1),
    .in_byte2  (in_byte2),
    .cmd       (front_cmd)
  );

  lpse_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_fire),
    .push_cmd (front_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .status   (q_status)
  );

  lpse_back #(
    .RESET_BYTES (RESET_BYTES)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_valid   (!q_status.empty),
    .head_cmd     (head_cmd),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_spi_byte (out_spi_byte),
    .out_last     (out_last)
  );

  a_sym_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_spi_byte == SYM_ONE || out_spi_byte == SYM_ZERO ||
                   out_spi_byte == SYM_RESET))
    else $error("illegal symbol byte");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_status.empty)
    else $error("pop from empty queue");

  a_queue_flags: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_status.full && q_status.empty))
    else $error("queue full and empty");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("reset did not clear output");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_spi_byte) && $stable(out_last)))
    else $error("output beat changed while stalled");

endmodule

@@ verif/tb_led_pixel_spi_symbol_encoder_core.sv @@
// ----------------------------------------------------------------------------
// tb_led_pixel_spi_symbol_encoder_core
// Self-checking bench for the LED pixel SPI symbol encoder. A directed script
// of register writes and pixel / frame-reset beats runs first, then random
// pixels and frame resets under four flow-control phases, with the registers
// reprogrammed between batches. Every symbol beat is scored in order against
// a local model of the position mask, the temperature step and bit expansion.
// ----------------------------------------------------------------------------
module tb_led_pixel_spi_symbol_encoder_core;
  timeunit 1ns;
  timeprecision 1ps;

  import lpse_pkg::*;

  localparam int RESET_LEN   = 33;
  localparam int SETTLE      = 8;
  localparam int TAIL        = 40;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 10;
  localparam int BATCH_BEATS = 28;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [GRADE_W-1:0] GRADE_NONE   = 3'd0;
  localparam logic [GRADE_W-1:0] GRADE_SPARE  = 3'd7;

  localparam int PHASE_IDLE  [4] = '{0, 58, 0, 9};
  localparam int PHASE_STALL [4] = '{0, 0, 58, 9};

  typedef enum logic {ROW_WRITE, ROW_BEAT} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] wdata;
    logic                  mode;
    logic [7:0]            b0;
    logic [7:0]            b1;
    logic [7:0]            b2;
    logic                  typed;
    logic [COLOR_W-1:0]    color;
  } row_t;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } spi_sym_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  logic                  in_mode   = 1'b0;
  logic [7:0]            in_byte0  = '0;
  logic [7:0]            in_byte1  = '0;
  logic [7:0]            in_byte2  = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [7:0]            out_spi_byte;
  logic                  out_last;

  logic [GRADE_W-1:0] grade_q = GRADE_NONE;
  logic [7:0]         step_q  = '0;
  logic [COLOR_W-1:0] blank_q = '0;
  logic [POS_W-1:0]   pos_q   = '0;

  spi_sym_t pending_syms[$];
  row_t     script[$];
  int       errors    = 0;
  int       cycles    = 0;
  int       idle_pct  = 0;
  int       stall_pct = 0;

  led_pixel_spi_symbol_encoder_core #(
    .RESET_BYTES(RESET_LEN)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_mode     (in_mode),
    .in_byte0    (in_byte0),
    .in_byte1    (in_byte1),
    .in_byte2    (in_byte2),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_spi_byte(out_spi_byte),
    .out_last    (out_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic bit roll(int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  // pos is the 0-based slot within the frame
  function automatic bit is_dimmed(logic [GRADE_W-1:0] grade, logic [POS_W-1:0] pos);
    int k;
    k = pos + 1;
    case (grade)
      GRADE_THIRD:     return (k % 3) == 0;
      GRADE_ALTERNATE: return (k % 2) == 0;
      GRADE_THREE_OF4: return (pos % 4) != 0;
      GRADE_ALL:       return 1'b1;
      default:         return 1'b0;
    endcase
  endfunction

  function automatic logic [COLOR_W-1:0] shade_pixel(logic [7:0] b0, logic [7:0] b1,
                                                     logic [7:0] b2);
    logic [7:0]         warm0;
    logic [7:0]         warm2;
    logic [COLOR_W-1:0] color;
    warm0 = b0 + {step_q[6:0], 1'b0};
    warm2 = b2 + {step_q[5:0], 2'b00};
    color = is_dimmed(grade_q, pos_q) ? blank_q : {warm0, b1, warm2};
    pos_q = (pos_q == POS_LAST) ? '0 : pos_q + 1'b1;
    return color;
  endfunction

  function automatic row_t wr(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    row_t r;
    r       = '0;
    r.kind  = ROW_WRITE;
    r.idx   = idx;
    r.wdata = d;
    return r;
  endfunction

  function automatic row_t px(logic mode, logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
                              logic typed, logic [COLOR_W-1:0] color);
    row_t r;
    r       = '0;
    r.kind  = ROW_BEAT;
    r.mode  = mode;
    r.b0    = b0;
    r.b1    = b1;
    r.b2    = b2;
    r.typed = typed;
    r.color = color;
    return r;
  endfunction

  task automatic note_error(string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("%s", msg);
  endtask

  task automatic queue_symbols(logic is_reset, logic [COLOR_W-1:0] color);
    spi_sym_t s;
    if (is_reset) begin
      for (int n = 0; n < RESET_LEN; n++) begin
        s.code = SYM_RESET;
        s.last = (n == RESET_LEN - 1);
        pending_syms.push_back(s);
      end
    end else begin
      for (int n = 0; n < PIXEL_BYTES; n++) begin
        s.code = color[COLOR_W-1-n] ? SYM_ONE : SYM_ZERO;
        s.last = (n == PIXEL_BYTES - 1);
        pending_syms.push_back(s);
      end
    end
  endtask

  task automatic apply_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    case (idx)
      REG_DIM_GRADE:   grade_q = d[GRADE_W-1:0];
      REG_TEMP_STEP:   step_q  = d[7:0];
      REG_BLANK_COLOR: blank_q = d[COLOR_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_write(idx, d);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_syms.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic send_beat(logic mode, logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
                           logic typed, logic [COLOR_W-1:0] typed_color);
    logic [COLOR_W-1:0] color;
    cfg_valid <= 1'b0;
    if (roll(idle_pct)) begin
      in_valid <= 1'b0;
      do @(posedge clk); while (roll(idle_pct));
    end
    in_valid <= 1'b1;
    in_mode  <= mode;
    in_byte0 <= b0;
    in_byte1 <= b1;
    in_byte2 <= b2;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (mode) begin
      pos_q = '0;
      queue_symbols(1'b1, '0);
    end else begin
      color = shade_pixel(b0, b1, b2);
      queue_symbols(1'b0, typed ? typed_color : color);
    end
  endtask

  task automatic pick_config();
    logic [CFG_DATA_W-1:0] d;
    write_reg(REG_DIM_GRADE, CFG_DATA_W'($urandom));
    case ($urandom_range(0, 3))
      0:       d = '0;
      1:       d = '1;
      default: d = CFG_DATA_W'($urandom);
    endcase
    write_reg(REG_TEMP_STEP, d);
    case ($urandom_range(0, 3))
      0:       d = '0;
      1:       d = '1;
      default: d = CFG_DATA_W'($urandom);
    endcase
    write_reg(REG_BLANK_COLOR, d);
    if (roll(25)) write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
  endtask

  always @(posedge clk) begin
    out_ready <= !roll(stall_pct);
  end

  always @(posedge clk) begin : score
    spi_sym_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_syms.size() == 0) begin
        note_error($sformatf("unexpected beat: spi_byte=%02h last=%0b",
                             out_spi_byte, out_last));
      end else begin
        want = pending_syms.pop_front();
        if (out_spi_byte !== want.code || out_last !== want.last) begin
          note_error($sformatf("beat spi_byte=%02h last=%0b, expected spi_byte=%02h last=%0b",
                               out_spi_byte, out_last, want.code, want.last));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("led_pixel_spi_symbol_encoder_core: mismatch");
      $finish;
    end
  end

  initial begin
    script = '{
      px(1'b0, 8'h00, 8'h00, 8'h00, 1'b1, 24'h000000),
      px(1'b0, 8'hFF, 8'hFF, 8'hFF, 1'b1, 24'hFFFFFF),
      px(1'b1, 8'hAA, 8'h55, 8'hFF, 1'b1, 24'h000000),
      wr(REG_TEMP_STEP, 24'hFFFFFF),
      px(1'b0, 8'h01, 8'h80, 8'h01, 1'b0, '0),
      wr(REG_BLANK_COLOR, 24'hA5C35A),
      wr(REG_DIM_GRADE, CFG_DATA_W'(GRADE_ALL)),
      px(1'b0, 8'h12, 8'h34, 8'h56, 1'b1, 24'hA5C35A),
      wr(REG_DIM_GRADE, CFG_DATA_W'(GRADE_SPARE)),
      wr(REG_UNUSED, 24'hFFFFFF),
      px(1'b0, 8'h10, 8'h20, 8'h30, 1'b0, '0),
      wr(REG_TEMP_STEP, 24'h000000),
      wr(REG_DIM_GRADE, CFG_DATA_W'(GRADE_THIRD)),
      px(1'b0, 8'h80, 8'h01, 8'h7F, 1'b0, '0),
      px(1'b0, 8'h55, 8'hAA, 8'h55, 1'b0, '0),
      px(1'b0, 8'hC3, 8'h3C, 8'h99, 1'b0, '0),
      px(1'b0, 8'h01, 8'h02, 8'h04, 1'b0, '0),
      px(1'b0, 8'h08, 8'h10, 8'h20, 1'b0, '0),
      px(1'b0, 8'h40, 8'h80, 8'hFE, 1'b0, '0),
      px(1'b0, 8'hFD, 8'hFB, 8'hF7, 1'b0, '0),
      px(1'b0, 8'hEF, 8'hDF, 8'hBF, 1'b0, '0),
      px(1'b0, 8'h7F, 8'h00, 8'hFF, 1'b0, '0),
      px(1'b0, 8'h96, 8'h69, 8'h0F, 1'b0, '0),
      px(1'b0, 8'hF0, 8'h0F, 8'hA5, 1'b0, '0),
      px(1'b0, 8'h5A, 8'hE1, 8'h1E, 1'b0, '0),
      wr(REG_DIM_GRADE, CFG_DATA_W'(GRADE_ALTERNATE)),
      wr(REG_BLANK_COLOR, 24'hFFFFFF),
      px(1'b0, 8'h24, 8'h42, 8'h81, 1'b0, '0),
      px(1'b0, 8'h18, 8'h81, 8'h3C, 1'b0, '0),
      wr(REG_DIM_GRADE, CFG_DATA_W'(GRADE_THREE_OF4)),
      wr(REG_TEMP_STEP, 24'h000041),
      px(1'b1, 8'h00, 8'h00, 8'h00, 1'b1, 24'h000000),
      px(1'b0, 8'hE7, 8'h7E, 8'hC9, 1'b0, '0),
      px(1'b0, 8'h33, 8'hCC, 8'h66, 1'b0, '0),
      px(1'b0, 8'h9C, 8'hC6, 8'h63, 1'b0, '0),
      px(1'b0, 8'hB4, 8'h4B, 8'hD2, 1'b0, '0)
    };

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      if (script[i].kind == ROW_WRITE) begin
        if (!cfg_valid) wait_idle();
        write_reg(script[i].idx, script[i].wdata);
      end else begin
        send_beat(script[i].mode, script[i].b0, script[i].b1, script[i].b2,
                  script[i].typed, script[i].color);
      end
    end

    // each batch drains fully before the registers change
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = PHASE_IDLE[ph];
      stall_pct = PHASE_STALL[ph];
      for (int batch = 0; batch < 2; batch++) begin
        wait_idle();
        pick_config();
        for (int i = 0; i < BATCH_BEATS; i++) begin
          send_beat(roll(8), 8'($urandom), 8'($urandom), 8'($urandom), 1'b0, '0);
        end
      end
    end

    in_valid <= 1'b0;
    while (pending_syms.size() != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);
    if (errors == 0) begin
      $display("led_pixel_spi_symbol_encoder_core: match");
    end else begin
      $display("led_pixel_spi_symbol_encoder_core: mismatch");
    end
    $finish;
  end

endmodule
